/* src/msds_pkg.sv */
// Shared constants, codes and channel types of the debounced square selector.
package msds_pkg;

   localparam int MAX_MENU_ITEMS = 8;
   localparam int CHANNELS       = MAX_MENU_ITEMS + 1;
   localparam int CH_IDX_W       = $clog2(CHANNELS);
   localparam int CNT_W          = $clog2(CHANNELS + 1);
   localparam int ITEM_SLOTS     = 8;
   localparam int SQ_W           = 6;
   localparam int ID_W           = 8;
   localparam int DB_W           = 8;
   localparam int OCC_W          = 64;
   localparam int COUNT_W        = 4;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 64;

   localparam logic [SQ_W-1:0] FLIP_MASK     = 6'h38;
   localparam logic [DB_W-1:0] DEBOUNCE_INIT = 8'd7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ITEM_COUNT,
      CSR_ITEM_SQUARES,
      CSR_ITEM_IDS,
      CSR_FLIP_ROWS,
      CSR_BACK_ENABLE,
      CSR_BACK_SQUARE,
      CSR_DEBOUNCE_COUNT
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_SCAN,
      PH_WAIT,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REMOVE,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic [OCC_W-1:0] sensor_occupancy;
      logic             restart;
   } req_type;

   typedef struct packed {
      logic            selection_valid;
      logic [ID_W-1:0] selection_id;
      logic            selection_is_back;
      logic            awaiting_removal;
      logic            session_done;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0]         item_count;
      logic [ITEM_SLOTS*SQ_W-1:0] item_squares;
      logic [ITEM_SLOTS*ID_W-1:0] item_ids;
      logic                       flip_rows;
      logic                       back_enable;
      logic [SQ_W-1:0]            back_square;
      logic [DB_W-1:0]            debounce_count;
   } cfg_type;

   typedef struct packed {
      logic load_req;
      logic clear_session;
      logic step;
      logic advance;
      logic set_winner;
      logic use_winner;
      logic set_result;
      logic load_rsp;
      logic awaiting;
      logic done;
   } cmd_type;

   typedef struct packed {
      logic restart;
      logic no_channels;
      logic last;
      logic hit;
      logic occupied;
   } sts_type;

endpackage

/* src/msds_datapath.sv */
// Datapath: request latch, per-channel debounce counters, winner and result registers.
module msds_datapath (
   input  logic              clock,
   input  logic              reset,
   input  msds_pkg::cfg_type cfg,
   input  msds_pkg::req_type req_data,
   input  msds_pkg::cmd_type cmd,
   output msds_pkg::sts_type sts,
   output msds_pkg::rsp_type rsp_data
);

   logic [msds_pkg::OCC_W-1:0]    occ_ff;
   logic [msds_pkg::CH_IDX_W-1:0] ch_ff, ch_in;
   logic [msds_pkg::CH_IDX_W-1:0] winner_ff;
   logic [msds_pkg::DB_W-1:0]     empty_ff [msds_pkg::CHANNELS];
   logic [msds_pkg::DB_W-1:0]     full_ff  [msds_pkg::CHANNELS];
   logic                          armed_ff [msds_pkg::CHANNELS];
   logic                          res_valid_ff, res_back_ff;
   logic [msds_pkg::ID_W-1:0]     res_id_ff;
   msds_pkg::rsp_type             rsp_data_ff;

   logic [msds_pkg::CNT_W-1:0]    n, total;
   logic [msds_pkg::CH_IDX_W-1:0] sel_ch;
   logic                          sel_is_item;
   logic [msds_pkg::SQ_W-1:0]     sq;
   logic                          occupied;
   logic [msds_pkg::DB_W-1:0]     need, empty_cur, full_cur, empty_in, full_in;
   logic                          armed_cur, armed_in;
   logic [msds_pkg::ID_W-1:0]     id_sel;

   always_comb begin
      if (int'(cfg.item_count) > msds_pkg::MAX_MENU_ITEMS) begin
         n = msds_pkg::CNT_W'(msds_pkg::MAX_MENU_ITEMS);
      end else begin
         n = msds_pkg::CNT_W'(cfg.item_count);
      end
      total = n + msds_pkg::CNT_W'(cfg.back_enable);
   end

   always_comb begin
      sel_ch      = cmd.use_winner ? winner_ff : ch_ff;
      sel_is_item = msds_pkg::CNT_W'(sel_ch) < n;
      sq          = cfg.back_square;
      if (sel_is_item) begin
         if (int'(sel_ch) < msds_pkg::ITEM_SLOTS) begin
            sq = cfg.item_squares[msds_pkg::SQ_W*int'(sel_ch) +: msds_pkg::SQ_W];
         end else begin
            sq = '0;
         end
      end
      if (cfg.flip_rows) begin
         sq = sq ^ msds_pkg::FLIP_MASK;
      end
      occupied = occ_ff[sq];
      id_sel   = '0;
      if (sel_is_item && int'(sel_ch) < msds_pkg::ITEM_SLOTS) begin
         id_sel = cfg.item_ids[msds_pkg::ID_W*int'(sel_ch) +: msds_pkg::ID_W];
      end
   end

   always_comb begin
      need      = cfg.debounce_count;
      empty_cur = empty_ff[ch_ff];
      full_cur  = full_ff[ch_ff];
      armed_cur = armed_ff[ch_ff];
      empty_in  = empty_cur;
      full_in   = full_cur;
      armed_in  = armed_cur;
      if (!occupied) begin
         if (empty_cur < need) begin
            empty_in = empty_cur + msds_pkg::DB_W'(1);
         end
         full_in = '0;
         if (empty_in >= need) begin
            armed_in = 1'b1;
         end
      end else begin
         empty_in = '0;
         if (armed_cur) begin
            if (full_cur < need) begin
               full_in = full_cur + msds_pkg::DB_W'(1);
            end
         end else begin
            full_in = '0;
         end
      end
   end

   always_comb begin
      ch_in = ch_ff;
      if (cmd.load_req) begin
         ch_in = '0;
      end else if (cmd.advance) begin
         ch_in = ch_ff + msds_pkg::CH_IDX_W'(1);
      end
   end

   always_comb begin
      sts.restart     = req_data.restart;
      sts.no_channels = total == '0;
      sts.last        = (msds_pkg::CNT_W'(ch_ff) + msds_pkg::CNT_W'(1)) == total;
      sts.hit         = armed_in && (full_in >= need);
      sts.occupied    = occupied;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         occ_ff <= req_data.sensor_occupancy;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff.selection_valid   <= res_valid_ff;
         rsp_data_ff.selection_id      <= res_id_ff;
         rsp_data_ff.selection_is_back <= res_back_ff;
         rsp_data_ff.awaiting_removal  <= cmd.awaiting;
         rsp_data_ff.session_done      <= cmd.done;
      end
      if (cmd.load_req) begin
         res_valid_ff <= 1'b0;
         res_id_ff    <= '0;
         res_back_ff  <= 1'b0;
      end else if (cmd.set_result) begin
         res_valid_ff <= 1'b1;
         res_id_ff    <= id_sel;
         res_back_ff  <= !sel_is_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff <= '0;
      end else begin
         ch_ff <= ch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_session) begin
         winner_ff <= '0;
         for (int i = 0; i < msds_pkg::CHANNELS; i++) begin
            empty_ff[i] <= '0;
            full_ff[i]  <= '0;
            armed_ff[i] <= 1'b0;
         end
      end else begin
         if (cmd.step) begin
            empty_ff[ch_ff] <= empty_in;
            full_ff[ch_ff]  <= full_in;
            armed_ff[ch_ff] <= armed_in;
         end
         if (cmd.set_winner) begin
            winner_ff <= ch_ff;
         end
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

/* src/msds_controller.sv */
// Controller: request sequencing, session phase and result handshake.
module msds_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  msds_pkg::sts_type sts,
   output msds_pkg::cmd_type cmd
);

   msds_pkg::state_type state_ff, state_in;
   msds_pkg::phase_type phase_ff, phase_in, phase_next;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msds_pkg::ST_IDLE;
         phase_ff     <= msds_pkg::PH_SCAN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.awaiting = phase_ff == msds_pkg::PH_WAIT;
      cmd.done     = phase_ff == msds_pkg::PH_DONE;
      state_in     = state_ff;
      phase_in     = phase_ff;
      phase_next   = phase_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         msds_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req      = 1'b1;
               cmd.clear_session = sts.restart;
               if (sts.restart) begin
                  phase_next = msds_pkg::PH_SCAN;
               end
               phase_in = phase_next;
               unique case (phase_next)
                  msds_pkg::PH_SCAN: begin
                     state_in = sts.no_channels ? msds_pkg::ST_RESPOND : msds_pkg::ST_SCAN;
                  end
                  msds_pkg::PH_WAIT: state_in = msds_pkg::ST_REMOVE;
                  default:           state_in = msds_pkg::ST_RESPOND;
               endcase
            end
         end
         msds_pkg::ST_SCAN: begin
            cmd.step = 1'b1;
            priority if (sts.hit) begin
               cmd.set_winner = 1'b1;
               phase_in       = msds_pkg::PH_WAIT;
               state_in       = msds_pkg::ST_RESPOND;
            end else if (sts.last) begin
               state_in = msds_pkg::ST_RESPOND;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         msds_pkg::ST_REMOVE: begin
            cmd.use_winner = 1'b1;
            if (!sts.occupied) begin
               cmd.set_result = 1'b1;
               phase_in       = msds_pkg::PH_DONE;
            end
            state_in = msds_pkg::ST_RESPOND;
         end
         msds_pkg::ST_RESPOND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = msds_pkg::ST_IDLE;
            end
         end
         default: state_in = msds_pkg::ST_IDLE;
      endcase
   end

   assign req_stall = state_ff != msds_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_scan_phase: assert property (@(posedge clock) disable iff (reset)
      state_ff == msds_pkg::ST_SCAN |-> phase_ff == msds_pkg::PH_SCAN)
      else $error("channel scan outside scanning phase");

   a_remove_phase: assert property (@(posedge clock) disable iff (reset)
      state_ff == msds_pkg::ST_REMOVE |-> phase_ff == msds_pkg::PH_WAIT)
      else $error("removal check without a pending selection");

   a_win_waits: assert property (@(posedge clock) disable iff (reset)
      cmd.set_winner |=> phase_ff == msds_pkg::PH_WAIT && state_ff == msds_pkg::ST_RESPOND)
      else $error("winning channel did not enter removal wait");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == msds_pkg::PH_DONE && !(cmd.load_req && sts.restart))
      |=> phase_ff == msds_pkg::PH_DONE)
      else $error("session left done without restart");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid_ff && state_ff == msds_pkg::ST_IDLE)
      else $error("loaded result not presented");
`endif

endmodule

/* src/multi_square_debounced_selector.sv */
// Top level of the debounced multi-square selector: register file and core wiring.
//
// Each request carries one 64-square occupancy scan and a restart flag; each
// request yields exactly one response with the selection flags and session state.
// Channels: req_valid/req_stall in, rsp_valid/rsp_stall out; a transfer happens
// on a clock edge with valid high and stall low. The csr_ port writes the
// configuration registers (index 0..6); csr_ready is always high and writes
// are expected only while the block is idle.
// Sequence: a request is taken in the idle state, then the channels are visited
// in scan order at one channel per cycle (up to 9, stopping at the first winner),
// or the removal check is made; then the response register is loaded once the
// output is free, and the response appears on the cycle after loading.
// A stalled response holds in its output register while the next request is
// taken; the following response waits until the held one is taken.
// Reset (synchronous) clears the configuration to defaults, all debounce
// counters, the session phase and any pending response.
module multi_square_debounced_selector (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  msds_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output msds_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [msds_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [msds_pkg::CSR_DATA_W-1:0]     csr_data
);

   msds_pkg::cfg_type cfg_ff;
   msds_pkg::cmd_type cmd;
   msds_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.item_count     <= '0;
         cfg_ff.item_squares   <= '0;
         cfg_ff.item_ids       <= '0;
         cfg_ff.flip_rows      <= 1'b0;
         cfg_ff.back_enable    <= 1'b0;
         cfg_ff.back_square    <= '0;
         cfg_ff.debounce_count <= msds_pkg::DEBOUNCE_INIT;
      end else if (csr_valid && csr_ready) begin
         unique case (msds_pkg::csr_index_type'(csr_index))
            msds_pkg::CSR_ITEM_COUNT:
               cfg_ff.item_count <= csr_data[msds_pkg::COUNT_W-1:0];
            msds_pkg::CSR_ITEM_SQUARES:
               cfg_ff.item_squares <= csr_data[msds_pkg::ITEM_SLOTS*msds_pkg::SQ_W-1:0];
            msds_pkg::CSR_ITEM_IDS:
               cfg_ff.item_ids <= csr_data[msds_pkg::ITEM_SLOTS*msds_pkg::ID_W-1:0];
            msds_pkg::CSR_FLIP_ROWS:      cfg_ff.flip_rows   <= csr_data[0];
            msds_pkg::CSR_BACK_ENABLE:    cfg_ff.back_enable <= csr_data[0];
            msds_pkg::CSR_BACK_SQUARE:
               cfg_ff.back_square <= csr_data[msds_pkg::SQ_W-1:0];
            msds_pkg::CSR_DEBOUNCE_COUNT:
               cfg_ff.debounce_count <= csr_data[msds_pkg::DB_W-1:0];
            default: begin
            end
         endcase
      end
   end

   msds_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   msds_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

/* tb/tb.sv */
// Self-checking testbench of the debounced multi-square selector.
module tb;

   localparam logic [msds_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   msds_pkg::req_type                req_data = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   msds_pkg::rsp_type                rsp_data;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [msds_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [msds_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   multi_square_debounced_selector u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Register copies
   logic [msds_pkg::COUNT_W-1:0]                   cfg_count   = '0;
   logic [msds_pkg::ITEM_SLOTS*msds_pkg::SQ_W-1:0] cfg_squares = '0;
   logic [msds_pkg::ITEM_SLOTS*msds_pkg::ID_W-1:0] cfg_ids     = '0;
   logic                                           cfg_flip    = 1'b0;
   logic                                           cfg_back_en = 1'b0;
   logic [msds_pkg::SQ_W-1:0]                      cfg_back_sq = '0;
   logic [msds_pkg::DB_W-1:0]                      cfg_need    = msds_pkg::DEBOUNCE_INIT;

   // Debounce and session state
   logic [msds_pkg::DB_W-1:0] empty_run [msds_pkg::CHANNELS] = '{default: '0};
   logic [msds_pkg::DB_W-1:0] occ_run   [msds_pkg::CHANNELS] = '{default: '0};
   logic                      armed     [msds_pkg::CHANNELS] = '{default: 1'b0};
   msds_pkg::phase_type       session   = msds_pkg::PH_SCAN;
   logic [3:0]                winner    = '0;

   msds_pkg::req_type pending_scans[$];
   msds_pkg::rsp_type expected_results[$];
   msds_pkg::rsp_type oldest;
   int      queued_count = 0;
   int      rsp_count = 0;
   int      error_count = 0;
   int      gap_pct = 0;
   int      hold_pct = 0;
   logic    req_accepted = 1'b0;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int live_items();
      return (cfg_count > msds_pkg::MAX_MENU_ITEMS) ? msds_pkg::MAX_MENU_ITEMS
                                                    : int'(cfg_count);
   endfunction

   function automatic logic [msds_pkg::SQ_W-1:0] channel_square(int ch, int n);
      if (ch < n) return cfg_squares[msds_pkg::SQ_W*ch +: msds_pkg::SQ_W];
      return cfg_back_sq;
   endfunction

   function automatic logic [msds_pkg::SQ_W-1:0] physical_square(
         logic [msds_pkg::SQ_W-1:0] sq);
      return cfg_flip ? (sq ^ msds_pkg::FLIP_MASK) : sq;
   endfunction

   function automatic msds_pkg::rsp_type select_step(msds_pkg::req_type r);
      msds_pkg::rsp_type res;
      int      n;
      int      total;
      logic    occ;
      logic    won;
      res = '0;
      n = live_items();
      if (r.restart) begin
         for (int c = 0; c < msds_pkg::CHANNELS; c++) begin
            empty_run[c] = '0;
            occ_run[c] = '0;
            armed[c] = 1'b0;
         end
         session = msds_pkg::PH_SCAN;
         winner = '0;
      end
      if (session == msds_pkg::PH_SCAN) begin
         total = n + (cfg_back_en ? 1 : 0);
         won = 1'b0;
         for (int ch = 0; ch < total && !won; ch++) begin
            occ = r.sensor_occupancy[physical_square(channel_square(ch, n))];
            if (!occ) begin
               if (empty_run[ch] < cfg_need) empty_run[ch] = empty_run[ch] + 1'b1;
               occ_run[ch] = '0;
               if (empty_run[ch] >= cfg_need) armed[ch] = 1'b1;
            end else begin
               empty_run[ch] = '0;
               if (armed[ch]) begin
                  if (occ_run[ch] < cfg_need) occ_run[ch] = occ_run[ch] + 1'b1;
               end else begin
                  occ_run[ch] = '0;
               end
            end
            if (armed[ch] && occ_run[ch] >= cfg_need) begin
               winner = ch[3:0];
               session = msds_pkg::PH_WAIT;
               won = 1'b1;
            end
         end
      end else if (session == msds_pkg::PH_WAIT) begin
         if (!r.sensor_occupancy[physical_square(channel_square(int'(winner), n))]) begin
            res.selection_valid = 1'b1;
            if (int'(winner) < n) begin
               res.selection_id = cfg_ids[msds_pkg::ID_W*winner +: msds_pkg::ID_W];
            end else begin
               res.selection_is_back = 1'b1;
            end
            session = msds_pkg::PH_DONE;
         end
      end
      res.awaiting_removal = (session == msds_pkg::PH_WAIT);
      res.session_done = (session >= msds_pkg::PH_DONE);
      return res;
   endfunction

   // Request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_accepted) begin
            if (pending_scans.size() != 0 && $urandom_range(99) >= gap_pct) begin
               req_data <= pending_scans.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < hold_pct);
      end
   end

   // Response monitor
   always @(posedge clock) begin
      req_accepted <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               oldest = expected_results.pop_front();
               rsp_count++;
               if (rsp_data.selection_valid !== oldest.selection_valid) begin
                  $error("selection_valid: expected %0d, got %0d",
                         oldest.selection_valid, rsp_data.selection_valid);
                  error_count++;
               end
               if (rsp_data.selection_id !== oldest.selection_id) begin
                  $error("selection_id: expected %0d, got %0d",
                         oldest.selection_id, rsp_data.selection_id);
                  error_count++;
               end
               if (rsp_data.selection_is_back !== oldest.selection_is_back) begin
                  $error("selection_is_back: expected %0d, got %0d",
                         oldest.selection_is_back, rsp_data.selection_is_back);
                  error_count++;
               end
               if (rsp_data.awaiting_removal !== oldest.awaiting_removal) begin
                  $error("awaiting_removal: expected %0d, got %0d",
                         oldest.awaiting_removal, rsp_data.awaiting_removal);
                  error_count++;
               end
               if (rsp_data.session_done !== oldest.session_done) begin
                  $error("session_done: expected %0d, got %0d",
                         oldest.session_done, rsp_data.session_done);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) expected_results.push_back(select_step(req_data));
      end
   end

   function automatic void push_scan(logic [msds_pkg::OCC_W-1:0] occ, logic restart);
      msds_pkg::req_type r;
      r.sensor_occupancy = occ;
      r.restart = restart;
      pending_scans.push_back(r);
      queued_count++;
   endfunction

   function automatic logic [msds_pkg::OCC_W-1:0] rand_occ();
      logic [msds_pkg::OCC_W-1:0] a;
      logic [msds_pkg::OCC_W-1:0] b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case ($urandom_range(2))
         0: begin
            return a;
         end
         1: begin
            return a & b;
         end
         default: begin
            return a | b;
         end
      endcase
   endfunction

   task automatic wait_drained();
      while (rsp_count != queued_count) @(negedge clock);
   endtask

   task automatic write_reg(logic [msds_pkg::CSR_IDX_W-1:0] idx,
                            logic [msds_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         msds_pkg::CSR_ITEM_COUNT: begin
            cfg_count = val[msds_pkg::COUNT_W-1:0];
         end
         msds_pkg::CSR_ITEM_SQUARES: begin
            cfg_squares = val[msds_pkg::ITEM_SLOTS*msds_pkg::SQ_W-1:0];
         end
         msds_pkg::CSR_ITEM_IDS: begin
            cfg_ids = val;
         end
         msds_pkg::CSR_FLIP_ROWS: begin
            cfg_flip = val[0];
         end
         msds_pkg::CSR_BACK_ENABLE: begin
            cfg_back_en = val[0];
         end
         msds_pkg::CSR_BACK_SQUARE: begin
            cfg_back_sq = val[msds_pkg::SQ_W-1:0];
         end
         msds_pkg::CSR_DEBOUNCE_COUNT: begin
            cfg_need = val[msds_pkg::DB_W-1:0];
         end
         default: begin
         end
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_settings(logic [msds_pkg::COUNT_W-1:0] count, logic [47:0] squares,
                                 logic [63:0] ids, logic flip, logic back_en,
                                 logic [msds_pkg::SQ_W-1:0] back_sq,
                                 logic [msds_pkg::DB_W-1:0] need,
                                 int send_gap, int recv_hold);
      wait_drained();
      repeat (4) @(negedge clock);
      write_reg(msds_pkg::CSR_ITEM_COUNT, 64'(count));
      write_reg(msds_pkg::CSR_ITEM_SQUARES, 64'(squares));
      write_reg(msds_pkg::CSR_ITEM_IDS, ids);
      write_reg(msds_pkg::CSR_FLIP_ROWS, 64'(flip));
      write_reg(msds_pkg::CSR_BACK_ENABLE, 64'(back_en));
      write_reg(msds_pkg::CSR_BACK_SQUARE, 64'(back_sq));
      write_reg(msds_pkg::CSR_DEBOUNCE_COUNT, 64'(need));
      gap_pct = send_gap;
      hold_pct = recv_hold;
   endtask

   // Empty run, occupied run, then lift; sometimes broken by one wrong reading in each run
   task automatic queue_session();
      int                         n;
      int                         total;
      int                         target;
      int                         runs;
      int                         hold;
      int                         slip;
      logic                       broken;
      logic [msds_pkg::SQ_W-1:0]  spot;
      logic [msds_pkg::OCC_W-1:0] occ;
      n = live_items();
      total = n + (cfg_back_en ? 1 : 0);
      push_scan(rand_occ(), $urandom_range(99) < 85);
      if (total == 0) begin
         repeat ($urandom_range(4) + 1) push_scan(rand_occ(), $urandom_range(9) == 0);
      end else begin
         target = $urandom_range(total - 1);
         spot = physical_square(channel_square(target, n));
         runs = (cfg_need == 0) ? 1 : int'(cfg_need);
         hold = runs + $urandom_range(3);
         broken = ($urandom_range(9) == 0);
         slip = $urandom_range(runs - 1);
         for (int k = 0; k < runs; k++) begin
            occ = rand_occ();
            occ[spot] = broken && (k == slip);
            push_scan(occ, 1'b0);
         end
         for (int k = 0; k < hold; k++) begin
            occ = rand_occ();
            occ[spot] = !(broken && (k == slip));
            push_scan(occ, 1'b0);
         end
         occ = rand_occ();
         occ[spot] = 1'b0;
         push_scan(occ, 1'b0);
         repeat ($urandom_range(2)) push_scan(rand_occ(), 1'b0);
      end
   endtask

   task automatic run_phase(int budget);
      int start;
      start = queued_count;
      while (queued_count - start < budget) queue_session();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // No channels in use
      push_scan('0, 1'b0);
      push_scan('1, 1'b1);

      // Three items at squares 0, 9, 63 with ids 0x00, 0xFF, 0x5A; back at 27
      apply_settings(4'd3, 48'h3F240, 64'h5AFF00, 1'b0, 1'b1, 6'd27, 8'd1, 0, 0);
      write_reg(CSR_UNUSED, '1);
      push_scan('0, 1'b1);
      push_scan(64'(1) << 9, 1'b0);
      push_scan(64'(1) << 9, 1'b0);
      push_scan('0, 1'b0);
      push_scan('1, 1'b0);
      push_scan('0, 1'b1);
      push_scan(64'(1) << 27, 1'b0);
      push_scan('0, 1'b0);

      // Clamped count, mirrored rows, zero debounce
      apply_settings(4'd15, 48'h3F240, 64'h5AFF00, 1'b1, 1'b1, 6'd27, 8'd0, 0, 0);
      push_scan('1, 1'b1);
      push_scan(~(64'(1) << 49), 1'b0);
      push_scan('0, 1'b0);
      push_scan('1, 1'b0);

      apply_settings(4'd8, 48'({$urandom, $urandom}), {$urandom, $urandom}, 1'b0, 1'b1,
                     6'($urandom), 8'd2, 0, 0);
      run_phase(40);
      apply_settings(4'($urandom_range(8, 1)), 48'({$urandom, $urandom}),
                     {$urandom, $urandom}, 1'b1, 1'b0, 6'($urandom),
                     8'($urandom_range(4, 1)), 68, 0);
      run_phase(40);
      apply_settings(4'd0, '0, '0, 1'b0, 1'b1, 6'd63, 8'd3, 0, 68);
      run_phase(25);
      apply_settings(4'($urandom_range(15, 9)), '1, '1, 1'($urandom), 1'($urandom),
                     6'($urandom), 8'd1, 22, 22);
      run_phase(40);
      apply_settings(4'd1, 48'({$urandom, $urandom}), {$urandom, $urandom}, 1'b0, 1'b0,
                     '0, 8'd255, 22, 22);
      run_phase(1);
      apply_settings(4'($urandom_range(8, 1)), 48'({$urandom, $urandom}),
                     {$urandom, $urandom}, 1'($urandom), 1'b1, 6'($urandom),
                     8'($urandom_range(5, 1)), 0, 0);
      run_phase(30);

      wait_drained();
      repeat (20) @(negedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
